[src/div64_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package div64_pkg;

   localparam int unsigned DATA_WIDTH  = 64;
   localparam int unsigned FIELD_WIDTH = 64;
   localparam int unsigned TDATA_WIDTH = 2 * FIELD_WIDTH;

   typedef struct packed {
      logic       neg_q;
      logic       neg_r;
      logic       dbz;
   } flags_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] nq;
      logic [DATA_WIDTH-1:0] den;
      flags_type             flags;
   } work_type;

endpackage

`default_nettype wire

[src/divider_64bit_signed_unsigned_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, unsigned or signed (truncating), giving quotient and
// remainder of 64-bit operands. One beat is accepted per clock unless the pipeline is
// held. One stage takes absolute values, a row of DATA_WIDTH identical cells retires
// one quotient bit each, and a last stage fixes the signs into the output register.
// The whole pipeline advances together and holds only while a result beat is waiting
// on rsp_tready. A zero divisor returns zero quotient and remainder with rsp_tuser
// set; the most negative value divided by minus one wraps to the most negative value.

module divider_64bit_signed_unsigned_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [div64_pkg::TDATA_WIDTH-1:0]   req_tdata,  // dividend, divisor
   input  wire logic                                req_tuser,  // signed_mode
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [div64_pkg::TDATA_WIDTH-1:0]   rsp_tdata,  // quotient, remainder
   output      logic                                rsp_tuser   // divide_by_zero
);

   localparam int unsigned W  = div64_pkg::DATA_WIDTH;
   localparam int unsigned FW = div64_pkg::FIELD_WIDTH;

   logic                advance;
   logic                stage_valid [0:W];
   div64_pkg::work_type stage_work  [0:W];
   logic [FW-1:0]       quotient;
   logic [FW-1:0]       remainder;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   div64_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_tvalid),
      .dividend    (req_tdata[FW-1:0]),
      .divisor     (req_tdata[2*FW-1:FW]),
      .signed_mode (req_tuser),
      .out_valid   (stage_valid[0]),
      .out_work    (stage_work[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_cell
      div64_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   div64_post u_post (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (stage_valid[W]),
      .in_work        (stage_work[W]),
      .out_valid      (rsp_tvalid),
      .quotient       (quotient),
      .remainder      (remainder),
      .divide_by_zero (rsp_tuser)
   );

   assign rsp_tdata = {remainder, quotient};

endmodule

`default_nettype wire

[src/div64_prep.sv]
`timescale 1ns / 1ps
`default_nettype none

module div64_prep (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic [div64_pkg::FIELD_WIDTH-1:0]   dividend,
   input  wire logic [div64_pkg::FIELD_WIDTH-1:0]   divisor,
   input  wire logic                                signed_mode,
   output      logic                                out_valid,
   output      div64_pkg::work_type                 out_work
);

   localparam int unsigned W = div64_pkg::DATA_WIDTH;

   logic [W-1:0]        num;
   logic [W-1:0]        den;
   logic                num_neg;
   logic                den_neg;
   logic                valid_ff;
   logic                valid_in;
   div64_pkg::work_type work_ff;
   div64_pkg::work_type work_in;

   always_comb begin
      num     = dividend[W-1:0];
      den     = divisor[W-1:0];
      num_neg = signed_mode & num[W-1];
      den_neg = signed_mode & den[W-1];
      valid_in = in_valid;
      work_in.rem         = '0;
      work_in.nq          = num_neg ? (~num + W'(1)) : num;
      work_in.den         = den_neg ? (~den + W'(1)) : den;
      work_in.flags.neg_q = num_neg ^ den_neg;
      work_in.flags.neg_r = num_neg;
      work_in.flags.dbz   = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

[src/div64_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module div64_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire div64_pkg::work_type in_work,
   output      logic                out_valid,
   output      div64_pkg::work_type out_work
);

   localparam int unsigned W = div64_pkg::DATA_WIDTH;

   logic                carry;
   logic [W-1:0]        shifted;
   logic [W:0]          diff;
   logic                take;
   logic                valid_ff;
   div64_pkg::work_type work_ff;
   div64_pkg::work_type work_in;

   always_comb begin
      carry   = in_work.rem[W-1];
      shifted = {in_work.rem[W-2:0], in_work.nq[W-1]};
      diff    = {carry, shifted} - {1'b0, in_work.den};
      take    = ~diff[W];
      work_in       = in_work;
      work_in.rem   = take ? diff[W-1:0] : shifted;
      work_in.nq    = {in_work.nq[W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

[src/div64_post.sv]
`timescale 1ns / 1ps
`default_nettype none

module div64_post (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire div64_pkg::work_type               in_work,
   output      logic                              out_valid,
   output      logic [div64_pkg::FIELD_WIDTH-1:0] quotient,
   output      logic [div64_pkg::FIELD_WIDTH-1:0] remainder,
   output      logic                              divide_by_zero
);

   localparam int unsigned W  = div64_pkg::DATA_WIDTH;
   localparam int unsigned FW = div64_pkg::FIELD_WIDTH;

   logic [W-1:0]  q_val;
   logic [W-1:0]  r_val;
   logic [FW-1:0] quot_ff;
   logic [FW-1:0] quot_in;
   logic [FW-1:0] rem_ff;
   logic [FW-1:0] rem_in;
   logic          dbz_ff;
   logic          dbz_in;
   logic          valid_ff;

   always_comb begin
      q_val = in_work.flags.neg_q ? (~in_work.nq + W'(1)) : in_work.nq;
      r_val = in_work.flags.neg_r ? (~in_work.rem + W'(1)) : in_work.rem;
      if (in_work.flags.dbz) begin
         q_val = '0;
         r_val = '0;
      end
      quot_in = FW'(q_val);
      rem_in  = FW'(r_val);
      dbz_in  = in_work.flags.dbz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         dbz_ff  <= dbz_in;
      end
   end

   assign out_valid      = valid_ff;
   assign quotient       = quot_ff;
   assign remainder      = rem_ff;
   assign divide_by_zero = dbz_ff;

endmodule

`default_nettype wire
